### rtl/core/tklm_pkg.sv
// ----------------------------------------------------------------------------
// tklm_pkg
// Shared types and constants of the top-k logit mask unit.
// ----------------------------------------------------------------------------
package tklm_pkg;

  // default number of cells, largest row the unit can buffer
  localparam int unsigned ROW_MAX_DEF = 64;

  // fixed field widths
  localparam int unsigned LOGIT_W = 16;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd1;
  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 7'd64;

  // code standing for minus infinity
  localparam logic signed [LOGIT_W-1:0] NEG_INF_CODE = 16'sh8000;

  typedef logic signed [LOGIT_W-1:0] logit_t;

  typedef struct packed {
    logit_t logit_value;
  } in_item_t;

  typedef struct packed {
    logit_t masked_value;
    logic   kept;
    logic   last_of_row;
  } out_item_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic   ins_en;    // insert the broadcast logit this cycle
    logic   shift_en;  // move arrival order one cell toward the head
    logit_t logit;     // logit being inserted
  } cell_ctrl_t;

endpackage

### rtl/core/tklm_if.sv
// ----------------------------------------------------------------------------
// tklm_in_if / tklm_out_if
// Valid/ready channels carrying the input logits and the masked results.
// ----------------------------------------------------------------------------
interface tklm_in_if;
  logic               valid;
  logic               ready;
  tklm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tklm_out_if;
  logic                valid;
  logic                ready;
  tklm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tklm_cell.sv
// ----------------------------------------------------------------------------
// tklm_cell
// One cell: a slot of the descending insertion chain and a slot of the
// arrival-order buffer.
// ----------------------------------------------------------------------------
module tklm_cell #(
  parameter int unsigned ROW_MAX = tklm_pkg::ROW_MAX_DEF,
  parameter int unsigned IDX     = 0,
  localparam int unsigned CNT_W  = $clog2(ROW_MAX + 1)
) (
  input  logic                 clk,
  input  tklm_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     count,
  input  logic                 left_move,
  input  tklm_pkg::logit_t     left_sorted,
  input  tklm_pkg::logit_t     right_row,
  output logic                 move,
  output tklm_pkg::logit_t     sorted,
  output tklm_pkg::logit_t     row
);
  import tklm_pkg::*;

  logit_t sorted_r, sorted_nxt;
  logit_t row_r, row_nxt;
  logic   empty;
  logic   at_tail;

  assign empty   = CNT_W'(IDX) >= count;
  assign at_tail = CNT_W'(IDX) == count;

  // an empty slot counts as smaller than anything
  assign move = empty || (sorted_r < ctrl.logit);

  always_comb begin
    sorted_nxt = sorted_r;
    if (ctrl.ins_en && move) begin
      sorted_nxt = left_move ? left_sorted : ctrl.logit;
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (ctrl.ins_en && at_tail) begin
      row_nxt = ctrl.logit;
    end else if (ctrl.shift_en) begin
      row_nxt = right_row;
    end
  end

  always_ff @(posedge clk) begin
    sorted_r <= sorted_nxt;
    row_r    <= row_nxt;
  end

  assign sorted = sorted_r;
  assign row    = row_r;

endmodule

### rtl/core/top_k_logit_mask_unit.sv
// ----------------------------------------------------------------------------
// top_k_logit_mask_unit
// Top-k mask over one row of signed Q8.8 logits.
// ----------------------------------------------------------------------------
// Logits of a row are taken one per cycle. Each one is broadcast to a row of
// ROW_MAX cells that keeps the row sorted largest first (every cell compares
// and takes its left neighbor's value or the new logit) and also stores it in
// arrival order. The transfer that completes the row (count reaches
// row_length, 0 read as 1, above ROW_MAX read as ROW_MAX) is followed by a
// state that latches the k-th largest value as threshold (keep_count 0 read
// as 1). The row is then sent out in arrival order, one result per cycle
// while the receiver is ready, shifted out of the head cell: an element at
// least the threshold passes, so ties may keep more than k; others become
// -32768 with kept low. If k exceeds the row length, all elements are kept.
// All results leave through the single output point at the head of the
// arrival chain; no input is taken from row completion until the last
// result has moved into the output register. No clearing pass follows
// reset. Configuration is to be written between rows; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module top_k_logit_mask_unit #(
  parameter int unsigned ROW_MAX = tklm_pkg::ROW_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tklm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tklm_pkg::CFG_W-1:0]       cfg_data,
  tklm_in_if.sink                          in_ch,
  tklm_out_if.source                       out_ch
);
  import tklm_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROW_MAX + 1);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_THRESH,
    ST_EMIT
  } state_t;

  // configuration registers
  logic [CFG_W-1:0] keep_count_r;
  logic [CFG_W-1:0] row_length_r;

  // sequencer
  state_t           state_r;
  logic [CNT_W-1:0] count_r;      // buffered logits, later results still to send
  logit_t           thr_r;
  logic             keep_all_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // cell chain wires
  cell_ctrl_t       ctrl;
  logic   [ROW_MAX-1:0] move;
  logit_t [ROW_MAX-1:0] sorted;
  logit_t [ROW_MAX-1:0] row;

  logic             in_xfer;
  logic             load_out;
  logic [CFG_W-1:0] eff_len;
  logic [CFG_W-1:0] eff_k;
  logic [CFG_W-1:0] count_ext;
  logit_t           thr_sel;
  logic             head_kept;

  // effective row length and keep count
  always_comb begin
    priority if (row_length_r == '0) begin
      eff_len = CFG_W'(1);
    end else if (row_length_r > CFG_W'(ROW_MAX)) begin
      eff_len = CFG_W'(ROW_MAX);
    end else begin
      eff_len = row_length_r;
    end
  end

  assign eff_k     = (keep_count_r == '0) ? CFG_W'(1) : keep_count_r;
  assign count_ext = CFG_W'(count_r);

  // k-th largest out of the sorted chain
  always_comb begin
    thr_sel = sorted[0];
    for (int i = 0; i < ROW_MAX; i++) begin
      if (eff_k == CFG_W'(i + 1)) begin
        thr_sel = sorted[i];
      end
    end
  end

  assign in_ch.ready = (state_r == ST_COLLECT);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign ctrl.ins_en   = in_xfer;
  assign ctrl.shift_en = load_out;
  assign ctrl.logit    = in_ch.data.logit_value;

  // chain of cells, neighbor links at both ends tied off
  for (genvar g = 0; g < ROW_MAX; g++) begin : g_cell
    logic   l_move;
    logit_t l_sorted;
    logit_t r_row;

    if (g == 0) begin : g_head
      assign l_move   = 1'b0;
      assign l_sorted = '0;
    end else begin : g_link_l
      assign l_move   = move[g-1];
      assign l_sorted = sorted[g-1];
    end

    if (g == ROW_MAX - 1) begin : g_tail
      assign r_row = '0;
    end else begin : g_link_r
      assign r_row = row[g+1];
    end

    tklm_cell #(
      .ROW_MAX (ROW_MAX),
      .IDX     (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_move   (l_move),
      .left_sorted (l_sorted),
      .right_row   (r_row),
      .move        (move[g]),
      .sorted      (sorted[g]),
      .row         (row[g])
    );
  end

  // head of the arrival chain against the threshold
  assign head_kept = keep_all_r || (row[0] >= thr_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_COUNT_RST;
      row_length_r <= ROW_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_COUNT: keep_count_r <= cfg_data;
        REG_ROW_LENGTH: row_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      keep_all_r  <= 1'b0;
    end else begin
      // result taken and nothing new loaded
      if (out_ch.ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_COLLECT: begin
          if (in_xfer) begin
            count_r <= count_r + CNT_W'(1);
            if (count_ext + CFG_W'(1) >= eff_len) begin
              state_r <= ST_THRESH;
            end
          end
        end
        ST_THRESH: begin
          thr_r      <= thr_sel;
          keep_all_r <= eff_k > count_ext;
          state_r    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) begin
            out_valid_r             <= 1'b1;
            out_data_r.masked_value <= head_kept ? row[0] : NEG_INF_CODE;
            out_data_r.kept         <= head_kept;
            out_data_r.last_of_row  <= (count_r == CNT_W'(1));
            count_r                 <= count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              state_r <= ST_COLLECT;
            end
          end
        end
        default: state_r <= ST_COLLECT;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

### sim/top_k_logit_mask_unit_tb.sv
// ----------------------------------------------------------------------------
// top_k_logit_mask_unit_tb
// Self-checking bench for the top-k logit mask unit. Rows of Q8.8 logits are
// streamed in under several register settings and idling patterns. A
// scoreboard recomputes each row's threshold and masked output and checks
// every result transfer in order.
// ----------------------------------------------------------------------------
module top_k_logit_mask_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tklm_pkg::*;

  localparam int unsigned RAND_ITEMS = 310;
  // settle cycles after the last result before touching the registers
  localparam int unsigned SETTLE = 4;
  // hard stop, far beyond the slowest legal run
  localparam int unsigned LIMIT_NS = 2_000_000;

  // --------------------------------------------------------------------------
  // scoreboard: row predictor plus in-order result checker
  // --------------------------------------------------------------------------
  class mask_scoreboard;
    logit_t           arrival_q[$];  // current row in arrival order
    logit_t           ranked_q[$];   // same row sorted largest first
    out_item_t        masked_q[$];   // predicted results not yet seen
    logic [CFG_W-1:0] keep_count;
    logic [CFG_W-1:0] row_length;
    int unsigned      fail_cnt;

    function new();
      keep_count = KEEP_COUNT_RST;
      row_length = ROW_LENGTH_RST;
      fail_cnt   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      if (index == REG_KEEP_COUNT) begin
        keep_count = value;
      end else if (index == REG_ROW_LENGTH) begin
        row_length = value;
      end
    endfunction

    // an accepted logit; on the row's last one the whole row is predicted
    function void note_logit(logit_t v);
      int unsigned pos;
      int unsigned need;
      int unsigned k;
      int unsigned n;
      logit_t      thr;
      bit          keep_all;
      out_item_t   item;

      arrival_q.push_back(v);
      pos = ranked_q.size();
      while (pos > 0 && ranked_q[pos-1] < v) pos--;
      ranked_q.insert(pos, v);

      n    = arrival_q.size();
      need = (row_length == 0) ? 1 :
             (row_length > ROW_MAX_DEF) ? ROW_MAX_DEF : row_length;
      if (n < need) return;

      k        = (keep_count == 0) ? 1 : keep_count;
      keep_all = (k > n);
      thr      = keep_all ? '0 : ranked_q[k-1];
      for (int i = 0; i < n; i++) begin
        item.kept         = keep_all || (arrival_q[i] >= thr);
        item.masked_value = item.kept ? arrival_q[i] : NEG_INF_CODE;
        item.last_of_row  = (i == n - 1);
        masked_q.push_back(item);
      end
      arrival_q.delete();
      ranked_q.delete();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;

      if (masked_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual masked_value=%0d kept=%0b last_of_row=%0b",
                 $time, got.masked_value, got.kept, got.last_of_row);
        fail_cnt++;
        return;
      end
      want = masked_q.pop_front();
      if (got.masked_value !== want.masked_value) begin
        $display("%0t: masked_value expected %0d actual %0d",
                 $time, want.masked_value, got.masked_value);
        fail_cnt++;
      end
      if (got.kept !== want.kept) begin
        $display("%0t: kept expected %0b actual %0b", $time, want.kept, got.kept);
        fail_cnt++;
      end
      if (got.last_of_row !== want.last_of_row) begin
        $display("%0t: last_of_row expected %0b actual %0b",
                 $time, want.last_of_row, got.last_of_row);
        fail_cnt++;
      end
    endfunction

    function int unsigned pending();
      return masked_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, channels, unit
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tklm_in_if  in_bus();
  tklm_out_if out_bus();

  mask_scoreboard sb;
  logit_t         row_q[$];        // logits of the next row to send
  int             send_idle_pct;   // chance per cycle that the sender holds off
  int             sink_stall_pct;  // chance per cycle that the receiver stalls

  always #4 clk = ~clk;

  top_k_logit_mask_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // --------------------------------------------------------------------------
  // driver tasks, all entered right after a rising edge
  // --------------------------------------------------------------------------

  // one logit: random hold-off, then present until the transfer happens
  task automatic send_logit(logit_t v);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.data.logit_value <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_logit(v);
  endtask

  task automatic send_row();
    foreach (row_q[i]) send_logit(row_q[i]);
  endtask

  // stop sending, let every predicted result drain, then let the unit settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both registers on back-to-back cycles, write enable held across them
  task automatic set_config(logic [CFG_W-1:0] keep, logic [CFG_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEEP_COUNT;
    cfg_data  <= keep;
    @(posedge clk);
    sb.write_reg(REG_KEEP_COUNT, keep);
    cfg_index <= REG_ROW_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    sb.write_reg(REG_ROW_LENGTH, len);
    cfg_we <= 1'b0;
  endtask

  // idling pattern for a phase: none, sender, receiver, both
  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_idle_pct = 65; sink_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  sink_stall_pct = 65; end
      default: begin send_idle_pct = 32; sink_stall_pct = 32; end
    endcase
  endtask

  // mostly full-range values, with extremes and a narrow band that forces ties
  function automatic logit_t pick_logit();
    case ($urandom_range(0, 9))
      0:       return logit_t'(32767);
      1:       return logit_t'(-32768);
      2, 3, 4: return logit_t'($urandom_range(0, 6) - 3);
      default: return logit_t'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // receiver: check on each accepted result, then pick next cycle's ready
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.data);
      out_bus.ready <= ($urandom_range(1, 100) > sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      sent;
    int unsigned      ph;
    int unsigned      rows;
    int unsigned      eff;
    logic [CFG_W-1:0] keep;
    logic [CFG_W-1:0] len;

    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.data       = '0;
    send_idle_pct     = 0;
    sink_stall_pct    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, threshold at zero
    set_config(7'd2, 7'd4);
    row_q = '{logit_t'(32767), logit_t'(-32768), logit_t'(0), logit_t'(-1)};
    send_row();
    wait_idle();

    // k of zero acts as one, so the max and its tie both stay
    set_config(7'd0, 7'd3);
    row_q = '{logit_t'(5), logit_t'(5), logit_t'(3)};
    send_row();
    wait_idle();

    // row length zero acts as one; k above the row keeps the minimum code
    set_config(7'd3, 7'd0);
    row_q = '{logit_t'(-32768)};
    send_row();
    row_q = '{logit_t'(16'h1234)};
    send_row();
    wait_idle();

    // k at the register maximum keeps everything
    set_config(7'd127, 7'd5);
    row_q = '{logit_t'(-32768), logit_t'(-32768), logit_t'(256), logit_t'(-256),
              logit_t'(7)};
    send_row();
    wait_idle();

    // ties at the threshold keep more than k
    set_config(7'd2, 7'd6);
    row_q = '{logit_t'(10), logit_t'(20), logit_t'(20), logit_t'(20), logit_t'(-5),
              logit_t'(10)};
    send_row();
    wait_idle();

    // random phases: mostly short rows, two full-width rows
    sent = 0;
    ph   = 0;
    while (sent < RAND_ITEMS) begin
      case (ph)
        0: begin
          // reset values written back explicitly
          keep = KEEP_COUNT_RST;
          len  = ROW_LENGTH_RST;
          rows = 1;
        end
        3: begin
          // row length above the buffer saturates to a full row
          keep = 7'd64;
          len  = 7'd127;
          rows = 1;
        end
        default: begin
          len  = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 10));
          keep = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(65, 127))
                                             : 7'($urandom_range(0, len + 2));
          rows = $urandom_range(2, 4);
        end
      endcase
      eff = (len == 0) ? 1 : (len > ROW_MAX_DEF) ? ROW_MAX_DEF : len;

      set_idling(ph);
      set_config(keep, len);
      for (int r = 0; r < rows; r++) begin
        // hold the sender until the unit has drained completely: in phase 1 before the second row, else at random
        if ((ph == 1 && r == 1) || $urandom_range(0, 9) == 0) wait_idle();
        row_q.delete();
        repeat (eff) row_q.push_back(pick_logit());
        send_row();
        sent += eff;
      end
      wait_idle();
      ph++;
    end

    if (sb.fail_cnt == 0) begin
      $display("top_k_logit_mask_unit verification clean");
    end else begin
      $display("top_k_logit_mask_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("top_k_logit_mask_unit verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/tklm_pkg.sv
rtl/core/tklm_if.sv
rtl/core/tklm_cell.sv
rtl/core/top_k_logit_mask_unit.sv
sim/top_k_logit_mask_unit_tb.sv
